// File: sv/iptc_pkg.sv
// Shared types, character codes and decode helpers for the IP address text classifier.
package iptc_pkg;

   typedef enum logic [1:0] {
      CLASS_NONE = 2'd0,
      CLASS_IPV4 = 2'd1,
      CLASS_IPV6 = 2'd2
   } address_class_type;

   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_F   = 8'h66;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;

   localparam int HEX_GROUP_MAX = 4;
   localparam int DEC_GROUP_MAX = 3;
   localparam int COLON_MAX     = 7;
   localparam int OCTET_MAX     = 255;
   localparam int DOTS_NEEDED   = 3;

   // Control from the request stage to the scanner.
   typedef struct packed {
      logic char_step;
      logic end_step;
   } step_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
             ((c >= CH_UP_A) && (c <= CH_UP_F));
   endfunction

endpackage

// File: sv/iptc_scan.sv
// Per-name scanner state: parallel IPv6 and IPv4 checks and the final decision.
module iptc_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  iptc_pkg::step_type         step,
   input  logic [7:0]                 ch,
   output iptc_pkg::address_class_type decision
);

   logic       at_first_char_ff, at_first_char_in;
   logic       bracket_lead_ff, bracket_lead_in;
   logic       dot_lead_ff, dot_lead_in;
   logic       six_failed_ff, six_failed_in;
   logic       six_handed_over_ff, six_handed_over_in;
   logic [3:0] colon_count_ff, colon_count_in;
   logic       pair_seen_ff, pair_seen_in;
   logic       prev_single_colon_ff, prev_single_colon_in;
   logic [2:0] hex_digits_ff, hex_digits_in;
   logic       four_failed_ff, four_failed_in;
   logic [2:0] dot_count_ff, dot_count_in;
   logic [1:0] dec_digits_ff, dec_digits_in;
   logic [9:0] group_value_ff, group_value_in;
   logic       group_follows_dot_ff, group_follows_dot_in;
   logic       prev_was_dot_ff, prev_was_dot_in;

   logic        c_colon, c_dot, c_dec, c_hex;
   logic [11:0] octet_sum;

   assign c_colon   = (ch == iptc_pkg::CH_COLON);
   assign c_dot     = (ch == iptc_pkg::CH_DOT);
   assign c_dec     = iptc_pkg::is_dec(ch);
   assign c_hex     = iptc_pkg::is_hex(ch);
   assign octet_sum = 12'(group_value_ff) * 12'd10 + 12'(ch - iptc_pkg::CH_ZERO);

   always_comb begin
      at_first_char_in     = at_first_char_ff;
      bracket_lead_in      = bracket_lead_ff;
      dot_lead_in          = dot_lead_ff;
      six_failed_in        = six_failed_ff;
      six_handed_over_in   = six_handed_over_ff;
      colon_count_in       = colon_count_ff;
      pair_seen_in         = pair_seen_ff;
      prev_single_colon_in = prev_single_colon_ff;
      hex_digits_in        = hex_digits_ff;
      four_failed_in       = four_failed_ff;
      dot_count_in         = dot_count_ff;
      dec_digits_in        = dec_digits_ff;
      group_value_in       = group_value_ff;
      group_follows_dot_in = group_follows_dot_ff;
      prev_was_dot_in      = prev_was_dot_ff;

      if (step.char_step) begin
         if (at_first_char_ff) begin
            at_first_char_in = 1'b0;
            if (ch == iptc_pkg::CH_BRACKET) bracket_lead_in = 1'b1;
            else if (c_dot)                 dot_lead_in = 1'b1;
         end

         // IPv6 side
         if (!six_failed_ff && !six_handed_over_ff) begin
            if (c_colon) begin
               if (colon_count_ff != 4'hF) colon_count_in = colon_count_ff + 4'd1;
               if (prev_single_colon_ff) begin
                  if (pair_seen_ff) six_failed_in = 1'b1;
                  pair_seen_in         = 1'b1;
                  prev_single_colon_in = 1'b0;
               end else begin
                  prev_single_colon_in = 1'b1;
               end
               hex_digits_in = '0;
            end else begin
               prev_single_colon_in = 1'b0;
               if (c_dot)                                         six_handed_over_in = 1'b1;
               else if (!c_hex)                                   six_failed_in = 1'b1;
               else if (hex_digits_ff >= 3'(iptc_pkg::HEX_GROUP_MAX)) six_failed_in = 1'b1;
               else                                               hex_digits_in = hex_digits_ff + 3'd1;
            end
         end

         // IPv4 side
         if (!four_failed_ff) begin
            if (c_dot) begin
               if (prev_was_dot_ff) four_failed_in = 1'b1;
               if (dot_count_ff != 3'd7) dot_count_in = dot_count_ff + 3'd1;
               dec_digits_in        = '0;
               group_value_in       = '0;
               group_follows_dot_in = 1'b1;
               prev_was_dot_in      = 1'b1;
            end else begin
               prev_was_dot_in = 1'b0;
               if (!c_dec) begin
                  four_failed_in = 1'b1;
               end else if (dec_digits_ff >= 2'(iptc_pkg::DEC_GROUP_MAX)) begin
                  four_failed_in = 1'b1;
               end else begin
                  dec_digits_in = dec_digits_ff + 2'd1;
                  // first group is never range checked
                  if (group_follows_dot_ff) begin
                     group_value_in = octet_sum[9:0];
                     if (octet_sum > 12'(iptc_pkg::OCTET_MAX)) four_failed_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      if (bracket_lead_ff)
         decision = iptc_pkg::CLASS_IPV6;
      else if (dot_lead_ff || six_failed_ff)
         decision = iptc_pkg::CLASS_NONE;
      else if (!six_handed_over_ff && colon_count_ff > 4'(iptc_pkg::COLON_MAX))
         decision = iptc_pkg::CLASS_NONE;
      else if (!six_handed_over_ff && colon_count_ff > 4'd1)
         decision = iptc_pkg::CLASS_IPV6;
      else if (four_failed_ff)
         decision = iptc_pkg::CLASS_NONE;
      else if (dot_count_ff == 3'(iptc_pkg::DOTS_NEEDED))
         decision = iptc_pkg::CLASS_IPV4;
      else
         decision = iptc_pkg::CLASS_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset || step.end_step) begin
         at_first_char_ff     <= 1'b1;
         bracket_lead_ff      <= 1'b0;
         dot_lead_ff          <= 1'b0;
         six_failed_ff        <= 1'b0;
         six_handed_over_ff   <= 1'b0;
         colon_count_ff       <= '0;
         pair_seen_ff         <= 1'b0;
         prev_single_colon_ff <= 1'b0;
         hex_digits_ff        <= '0;
         four_failed_ff       <= 1'b0;
         dot_count_ff         <= '0;
         dec_digits_ff        <= '0;
         group_value_ff       <= '0;
         group_follows_dot_ff <= 1'b0;
         prev_was_dot_ff      <= 1'b0;
      end else begin
         at_first_char_ff     <= at_first_char_in;
         bracket_lead_ff      <= bracket_lead_in;
         dot_lead_ff          <= dot_lead_in;
         six_failed_ff        <= six_failed_in;
         six_handed_over_ff   <= six_handed_over_in;
         colon_count_ff       <= colon_count_in;
         pair_seen_ff         <= pair_seen_in;
         prev_single_colon_ff <= prev_single_colon_in;
         hex_digits_ff        <= hex_digits_in;
         four_failed_ff       <= four_failed_in;
         dot_count_ff         <= dot_count_in;
         dec_digits_ff        <= dec_digits_in;
         group_value_ff       <= group_value_in;
         group_follows_dot_ff <= group_follows_dot_in;
         prev_was_dot_ff      <= prev_was_dot_in;
      end
   end

endmodule

// File: sv/ip_address_text_classifier_unit.sv
// Top level: request register, scanner and result register of the IP address text classifier.
// A host name is sent one character per request, then an end-marker request; each end marker
// yields one result (0 none, 1 IPv4, 2 IPv6) and characters yield none. One request is taken
// every cycle while req_ready is high: it is captured in the request register and applied to
// the scanner state when it leaves that register, where an end marker's result is written to
// the result register. Characters always drain; only an end marker meeting a full, unaccepted
// result register holds the request stage, and req_ready then drops until rsp_ready frees it.
module ip_address_text_classifier_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_address_class
);

   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [7:0] in_ch_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_class_ff;
   logic       advance;

   iptc_pkg::step_type          step;
   iptc_pkg::address_class_type decision;

   assign advance   = in_valid_ff && (!in_kind_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign step.char_step = advance && !in_kind_ff;
   assign step.end_step  = advance && in_kind_ff;

   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_comb begin
      if (step.end_step)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   iptc_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .ch       (in_ch_ff),
      .decision (decision)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_kind;
         in_ch_ff   <= req_ch;
      end
      if (step.end_step) begin
         rsp_class_ff <= decision;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_address_class = rsp_class_ff;

endmodule
